FILE: src/tsrc_pkg.sv
package tsrc_pkg;

  // frame kinds as carried on op
  typedef enum logic [1:0] {
    KIND_LEN_HDR     = 2'd0,
    KIND_REPORT_INFO = 2'd1,
    KIND_REPORT_DATA = 2'd2,
    KIND_RESULT_DATA = 2'd3
  } frame_kind_t;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_LEAD  = 3'd1,
    STATUS_BAD_SUM   = 3'd2,
    STATUS_TOO_LONG  = 3'd3,
    STATUS_BAD_SIZE  = 3'd4
  } status_t;

  localparam logic [7:0]  LEAD_BYTE      = 8'hAA;
  localparam logic [6:0]  POLL_BASE      = 7'h64;
  localparam logic [15:0] IDX_MAX        = 16'hFFFF;
  localparam logic [15:0] MAX_PKT_RESET  = 16'd1000;
  localparam logic [15:0] HDR_LAST_IDX   = 16'd7;
  localparam logic [15:0] RPT_MIN_IDX    = 16'd5;
  localparam logic [15:0] RES_MIN_IDX    = 16'd2;
  localparam logic [15:0] RPT_SUM_IDX    = 16'd6;
  localparam logic [15:0] RES_SUM_IDX    = 16'd3;
  localparam logic [15:0] RPT_OVERHEAD   = 16'd5;
  localparam logic [15:0] RES_OVERHEAD   = 16'd2;

  // frame state as seen after the current beat
  typedef struct packed {
    frame_kind_t kind;
    logic [15:0] idx;
    logic        lead_ok;
    logic [15:0] sum;
    logic [7:0]  tail_hi;
    logic [7:0]  tail_lo;
    logic [7:0]  field_high;
    logic [7:0]  field_low;
  } frame_view_t;

  // outcome of a frame check
  typedef struct packed {
    status_t     status;
    logic [15:0] length;
    logic [3:0]  err_nibble;
    logic        toggle_poll;
  } check_result_t;

endpackage

FILE: src/tsrc_frame.sv
module tsrc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           op,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           report_id,
  input  logic                 is_first,
  output tsrc_pkg::frame_view_t view
);

  tsrc_pkg::frame_kind_t frame_kind;
  logic [15:0]           byte_index;
  logic                  lead_ok;
  logic [15:0]           running_sum;
  logic [7:0]            tail_hi;
  logic [7:0]            tail_lo;
  logic [7:0]            field_high;
  logic [7:0]            field_low;

  tsrc_pkg::frame_kind_t kind_cur;
  logic [15:0]           idx_cur;
  logic [15:0]           sum_base;
  logic                  add_tail;
  logic [15:0]           byte_index_next;

  always_comb begin
    kind_cur = is_first ? tsrc_pkg::frame_kind_t'(op) : frame_kind;
    idx_cur  = is_first ? 16'd0 : byte_index;
    if (is_first) begin
      if (kind_cur == tsrc_pkg::KIND_REPORT_INFO || kind_cur == tsrc_pkg::KIND_REPORT_DATA) begin
        sum_base = {8'd0, report_id};
      end else begin
        sum_base = 16'd0;
      end
    end else begin
      sum_base = running_sum;
    end

    // the byte two places back joins the sum once past the fixed head
    if (kind_cur == tsrc_pkg::KIND_RESULT_DATA) begin
      add_tail = (idx_cur >= tsrc_pkg::RES_SUM_IDX);
    end else begin
      add_tail = (idx_cur >= tsrc_pkg::RPT_SUM_IDX);
    end

    view.kind       = kind_cur;
    view.idx        = idx_cur;
    view.lead_ok    = (idx_cur == 16'd0) ? (rx_byte == tsrc_pkg::LEAD_BYTE) : lead_ok;
    view.sum        = sum_base + (add_tail ? {8'd0, tail_hi} : 16'd0);
    view.tail_hi    = tail_lo;
    view.tail_lo    = rx_byte;
    view.field_high = (idx_cur == 16'd4) ? rx_byte : field_high;
    view.field_low  = (idx_cur == 16'd5) ? rx_byte : field_low;

    byte_index_next = (idx_cur == tsrc_pkg::IDX_MAX) ? tsrc_pkg::IDX_MAX : idx_cur + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind  <= tsrc_pkg::KIND_LEN_HDR;
      byte_index  <= 16'd0;
      lead_ok     <= 1'b0;
      running_sum <= 16'd0;
      tail_hi     <= 8'd0;
      tail_lo     <= 8'd0;
      field_high  <= 8'd0;
      field_low   <= 8'd0;
    end else if (accept) begin
      frame_kind  <= view.kind;
      byte_index  <= byte_index_next;
      lead_ok     <= view.lead_ok;
      running_sum <= view.sum;
      tail_hi     <= view.tail_hi;
      tail_lo     <= view.tail_lo;
      field_high  <= view.field_high;
      field_low   <= view.field_low;
    end
  end

endmodule

FILE: src/tsrc_check.sv
module tsrc_check (
  input  tsrc_pkg::frame_view_t   view,
  input  logic [15:0]             max_packet_bytes,
  output tsrc_pkg::check_result_t result
);

  logic        size_bad;
  logic [15:0] cks;
  logic [15:0] hdr_len;

  always_comb begin
    cks     = {view.tail_hi, view.tail_lo};
    hdr_len = {view.field_high, view.field_low};

    case (view.kind)
      tsrc_pkg::KIND_LEN_HDR,
      tsrc_pkg::KIND_REPORT_INFO: size_bad = (view.idx != tsrc_pkg::HDR_LAST_IDX);
      tsrc_pkg::KIND_REPORT_DATA: size_bad = (view.idx < tsrc_pkg::RPT_MIN_IDX);
      default:                    size_bad = (view.idx < tsrc_pkg::RES_MIN_IDX);
    endcase

    result.status      = tsrc_pkg::STATUS_OK;
    result.length      = 16'd0;
    result.err_nibble  = 4'd0;
    result.toggle_poll = 1'b0;

    // size first, then lead, then sum, then length limit
    if (size_bad) begin
      result.status = tsrc_pkg::STATUS_BAD_SIZE;
    end else if (!view.lead_ok) begin
      result.status = tsrc_pkg::STATUS_BAD_LEAD;
    end else if (view.sum != cks) begin
      result.status = tsrc_pkg::STATUS_BAD_SUM;
    end else begin
      case (view.kind)
        tsrc_pkg::KIND_LEN_HDR: begin
          result.length = hdr_len;
          if (hdr_len > max_packet_bytes) begin
            result.status = tsrc_pkg::STATUS_TOO_LONG;
          end
        end
        tsrc_pkg::KIND_REPORT_INFO: begin
          result.length     = {4'd0, view.field_high[3:0], view.field_low};
          result.err_nibble = view.field_high[7:4];
        end
        tsrc_pkg::KIND_REPORT_DATA: begin
          result.length = view.idx - tsrc_pkg::RPT_OVERHEAD;
        end
        default: begin
          result.length      = view.idx - tsrc_pkg::RES_OVERHEAD;
          result.toggle_poll = 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: src/touch_spi_response_checker.sv
// channel   | direction | handshake              | fields
// ----------+-----------+------------------------+-----------------------------------------
// in        | input     | in_valid / in_ready    | op, rx_byte, report_id, is_first, is_last
// out       | output    | out_valid / out_ready  | status, length_value, error_nibble,
//           |           |                        | poll_byte
// cfg       | input     | cfg_write_en           | cfg_write_data (max_packet_bytes)
//
// one byte per cycle while in_ready is high; a last-byte beat shows its result on the next cycle
// frame state and running sum update in the cycle the byte is taken
// in_ready is low only while a result sits unread in the output register
// sync reset clears frame state, poll toggle, output valid; limit goes to 1000
// bytes that are not last update state and give no result beat
module touch_spi_response_checker (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  report_id,
  input  logic        is_first,
  input  logic        is_last,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] length_value,
  output logic [3:0]  error_nibble,
  output logic [6:0]  poll_byte
);

  logic                    accept;
  logic                    emit;
  logic [15:0]             max_packet_bytes;
  logic                    poll_state;
  logic                    poll_state_next;
  tsrc_pkg::frame_view_t   view;
  tsrc_pkg::check_result_t result;

  // output register parts the sides; refill allowed on the draining cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = accept && is_last;

  // frame tracking: kind, index, lead flag, running sum, tail and field bytes
  tsrc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .rx_byte   (rx_byte),
    .report_id (report_id),
    .is_first  (is_first),
    .view      (view)
  );

  // end-of-frame checks and length decode
  tsrc_check u_check (
    .view             (view),
    .max_packet_bytes (max_packet_bytes),
    .result           (result)
  );

  // poll filler flips after every good result-data frame
  assign poll_state_next = poll_state ^ result.toggle_poll;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= tsrc_pkg::MAX_PKT_RESET;
    end else if (cfg_write_en) begin
      max_packet_bytes <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_state <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        poll_state <= poll_state_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result beat payload, loaded only with a last byte
  always_ff @(posedge clk) begin
    if (emit) begin
      status       <= result.status;
      length_value <= result.length;
      error_nibble <= result.err_nibble;
      poll_byte    <= tsrc_pkg::POLL_BASE + {6'd0, poll_state_next};
    end
  end

endmodule
